// File: sv/textured_column_rasterizer_unit_macros.svh
`ifndef TEXTURED_COLUMN_RASTERIZER_UNIT_MACROS_SVH
`define TEXTURED_COLUMN_RASTERIZER_UNIT_MACROS_SVH

// same-cycle implication, checked on clk_i, off while rst_ni is low
`define TCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i, off while rst_ni is low
`define TCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tcr_pkg.sv
`timescale 1ns / 1ps

package tcr_pkg;

  // geometry and store sizes
  localparam int VIEW_HEIGHT_DEF = 64;
  localparam int TEXEL_DEPTH     = 128;
  localparam int MAP_DEPTH       = 256;
  localparam int TEXEL_AW        = $clog2(TEXEL_DEPTH);
  localparam int MAP_AW          = $clog2(MAP_DEPTH);

  // field widths
  localparam int ACTION_W = 2;
  localparam int BYTE_W   = 8;
  localparam int ROW_W    = 6;
  localparam int COORD_W  = 32;
  localparam int FRAC_W   = 16;
  localparam int OFFSET_W = 16;
  localparam int CFG_IDX_W = 8;

  // texture coordinate alignment
  localparam int STEP_SHIFT  = 8 - 1;
  localparam int INDEX_SHIFT = 8 + 1;

  // item actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD_LIGHT = 2'd0,
    ACT_LOAD_TEXEL = 2'd1,
    ACT_DRAW       = 2'd2
  } action_e;

  // register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW = 8'd1;
  localparam logic [BYTE_W-1:0]    VIEW_WIDTH_RST = 8'd60;
  localparam logic [ROW_W-1:0]     CENTER_ROW_RST = 6'd32;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_DRAW
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_light;
    logic load_texel;
    logic start;
    logic issue;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic stage1_valid;
    logic advance;
    logic last_row;
    logic empty;
  } dp_status_t;

endpackage

// File: sv/tcr_if.sv
`timescale 1ns / 1ps

// input item channel
interface tcr_item_if;
  logic                          valid;
  logic                          ready;
  logic [tcr_pkg::ACTION_W-1:0]  action;
  logic [tcr_pkg::BYTE_W-1:0]    table_index;
  logic [tcr_pkg::BYTE_W-1:0]    table_value;
  logic [tcr_pkg::BYTE_W-1:0]    column_x;
  logic [tcr_pkg::ROW_W-1:0]     top_row;
  logic [tcr_pkg::ROW_W-1:0]     bottom_row;
  logic [tcr_pkg::COORD_W-1:0]   inverse_scale;
  logic signed [tcr_pkg::COORD_W-1:0] texture_mid;

  modport source (output valid, action, table_index, table_value, column_x, top_row,
                  bottom_row, inverse_scale, texture_mid, input ready);
  modport sink (input valid, action, table_index, table_value, column_x, top_row,
                bottom_row, inverse_scale, texture_mid, output ready);
endinterface

// pixel result channel
interface tcr_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [tcr_pkg::OFFSET_W-1:0]  pixel_offset;
  logic [tcr_pkg::BYTE_W-1:0]    pixel_color;
  logic                          last_pixel;

  modport source (output valid, pixel_offset, pixel_color, last_pixel, input ready);
  modport sink (input valid, pixel_offset, pixel_color, last_pixel, output ready);
endinterface

// register write channel
interface tcr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tcr_pkg::CFG_IDX_W-1:0]  index;
  logic [tcr_pkg::BYTE_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/tcr_datapath.sv
`timescale 1ns / 1ps

module tcr_datapath #(
  parameter int VIEW_HEIGHT = tcr_pkg::VIEW_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tcr_pkg::dp_cmd_t                cmd_i,
  output tcr_pkg::dp_status_t             status_o,
  input  logic                            cfg_we_i,
  input  logic [tcr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tcr_pkg::BYTE_W-1:0]      cfg_data_i,
  input  logic [tcr_pkg::BYTE_W-1:0]      table_index_i,
  input  logic [tcr_pkg::BYTE_W-1:0]      table_value_i,
  input  logic [tcr_pkg::BYTE_W-1:0]      column_x_i,
  input  logic [tcr_pkg::ROW_W-1:0]       top_row_i,
  input  logic [tcr_pkg::ROW_W-1:0]       bottom_row_i,
  input  logic [tcr_pkg::COORD_W-1:0]     inverse_scale_i,
  input  logic [tcr_pkg::COORD_W-1:0]     texture_mid_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [tcr_pkg::OFFSET_W-1:0]    pixel_offset_o,
  output logic [tcr_pkg::BYTE_W-1:0]      pixel_color_o,
  output logic                            last_pixel_o
);
  import tcr_pkg::*;

  localparam logic [ROW_W-1:0] LAST_VIEW_ROW = ROW_W'(VIEW_HEIGHT - 1);

  logic [BYTE_W-1:0]   view_width_q;
  logic [ROW_W-1:0]    center_row_q;

  logic [BYTE_W-1:0]   light_mem [MAP_DEPTH];
  logic [BYTE_W-1:0]   texel_mem [TEXEL_DEPTH];

  logic [FRAC_W-1:0]   step_q, frac_q;
  logic [OFFSET_W-1:0] off_q;
  logic [ROW_W-1:0]    row_q, bot_q;

  logic                v1_q, v2_q, last1_q, last2_q;
  logic [OFFSET_W-1:0] off1_q, off2_q;
  logic [BYTE_W-1:0]   texel_q, color_q;

  logic [ROW_W-1:0]    bot_clip;
  logic [FRAC_W-1:0]   step_in, mid_in, diff16, frac0;
  logic [ROW_W:0]      row_diff;
  logic [2*FRAC_W-1:0] diff_prod;
  logic [OFFSET_W-1:0] off0;
  logic                advance;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_width_q <= VIEW_WIDTH_RST;
      center_row_q <= CENTER_ROW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_VIEW_WIDTH: view_width_q <= cfg_data_i;
        CFG_CENTER_ROW: center_row_q <= cfg_data_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // column setup: clip, step, start fraction and start offset
  always_comb begin
    bot_clip  = (bottom_row_i > LAST_VIEW_ROW) ? LAST_VIEW_ROW : bottom_row_i;
    step_in   = inverse_scale_i[STEP_SHIFT +: FRAC_W];
    mid_in    = texture_mid_i[STEP_SHIFT +: FRAC_W];
    row_diff  = {1'b0, top_row_i} - {1'b0, center_row_q};
    diff16    = {{(FRAC_W - ROW_W - 1){row_diff[ROW_W]}}, row_diff};
    diff_prod = diff16 * step_in;
    frac0     = mid_in + diff_prod[FRAC_W-1:0];
    off0      = OFFSET_W'(top_row_i) * OFFSET_W'(view_width_q) + OFFSET_W'(column_x_i);
  end

  // whole pipeline moves when the output slot is free or being taken
  assign advance = !v2_q || out_ready_i;

  assign status_o.stage1_valid = v1_q;
  assign status_o.advance      = advance;
  assign status_o.last_row     = (row_q == bot_q);
  assign status_o.empty        = (bot_clip < top_row_i);

  // walk state of the column
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      step_q <= step_in;
      frac_q <= frac0;
      off_q  <= off0;
      row_q  <= top_row_i;
      bot_q  <= bot_clip;
    end else if (cmd_i.issue) begin
      frac_q <= frac_q + step_q;
      off_q  <= off_q + OFFSET_W'(view_width_q);
      row_q  <= row_q + ROW_W'(1);
    end
  end

  // table writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_light) begin
      light_mem[table_index_i[MAP_AW-1:0]] <= table_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_texel) begin
      texel_mem[table_index_i[TEXEL_AW-1:0]] <= table_value_i;
    end
  end

  // table reads, one stage each, registered data
  always_ff @(posedge clk_i) begin
    if (advance) begin
      texel_q <= texel_mem[frac_q[INDEX_SHIFT +: TEXEL_AW]];
      color_q <= light_mem[texel_q];
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      off1_q  <= off_q;
      last1_q <= (row_q == bot_q);
      off2_q  <= off1_q;
      last2_q <= last1_q;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (advance) begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
    end
  end

  assign out_valid_o    = v2_q;
  assign pixel_offset_o = off2_q;
  assign pixel_color_o  = color_q;
  assign last_pixel_o   = last2_q;

endmodule

// File: sv/tcr_controller.sv
`timescale 1ns / 1ps
`include "textured_column_rasterizer_unit_macros.svh"

module tcr_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tcr_pkg::ACTION_W-1:0]  action_i,
  input  tcr_pkg::dp_status_t           status_i,
  output tcr_pkg::dp_cmd_t              cmd_o
);
  import tcr_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && in_ready_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (action_i == ACT_DRAW) && !status_i.empty) begin
          state_d = ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (status_i.advance && status_i.last_row) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        // a queued pixel still has a table read ahead of it
        in_ready_o = !status_i.stage1_valid;
        if (in_valid_i && in_ready_o) begin
          unique case (action_i)
            ACT_LOAD_LIGHT: cmd_o.load_light = 1'b1;
            ACT_LOAD_TEXEL: cmd_o.load_texel = 1'b1;
            ACT_DRAW:       cmd_o.start      = !status_i.empty;
            default: ;
          endcase
        end
      end
      ST_DRAW: begin
        cmd_o.issue = status_i.advance;
      end
      default: ;
    endcase
  end

  `TCR_ASSERT_NOW(a_start_when_drained, cmd_o.start,
                  (state_q == ST_IDLE) && !status_i.stage1_valid, "draw started while busy")
  `TCR_ASSERT_NEXT(a_last_issue_ends, cmd_o.issue && status_i.last_row,
                   state_q == ST_IDLE, "column walk ran past its last row")
  `TCR_ASSERT_NEXT(a_load_stays_idle, cmd_o.load_light || cmd_o.load_texel,
                   state_q == ST_IDLE, "table load started a walk")
  `TCR_ASSERT_NOW(a_no_accept_in_draw, state_q == ST_DRAW, !in_ready_o,
                  "item accepted during a column walk")

endmodule

// File: sv/textured_column_rasterizer_unit.sv
`timescale 1ns / 1ps
// channel     | dir | payload
// item_in     | in  | action, table_index, table_value, column_x, top/bottom row, scale, mid
// pixel_out   | out | pixel_offset, pixel_color, last_pixel
// cfg_in      | in  | index (0 view_width, 1 center_row), data; always ready
//
// a load item writes its table when taken; a draw item loads the walk setup and then
// walks its rows (up to VIEW_HEIGHT), the walk counter issuing one pixel a cycle,
// unless pixel_out stalls, into a two-stage texel / light map read pipeline.
// the next item is taken once the last pixel has left the first read stage.
// a stall on pixel_out freezes the whole pipeline; no pixel is dropped.
// reset clears control, stage valids and the config registers; the two tables are not cleared.

module textured_column_rasterizer_unit #(
  parameter int VIEW_HEIGHT = tcr_pkg::VIEW_HEIGHT_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  tcr_item_if.sink   item_in,
  tcr_pixel_if.source pixel_out,
  tcr_cfg_if.sink    cfg_in
);
  import tcr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // register port never stalls
  assign cfg_in.ready = 1'b1;

  tcr_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_in.valid),
    .in_ready_o (item_in.ready),
    .action_i   (item_in.action),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcr_datapath #(
    .VIEW_HEIGHT (VIEW_HEIGHT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_in.valid),
    .cfg_index_i     (cfg_in.index),
    .cfg_data_i      (cfg_in.data),
    .table_index_i   (item_in.table_index),
    .table_value_i   (item_in.table_value),
    .column_x_i      (item_in.column_x),
    .top_row_i       (item_in.top_row),
    .bottom_row_i    (item_in.bottom_row),
    .inverse_scale_i (item_in.inverse_scale),
    .texture_mid_i   (item_in.texture_mid),
    .out_ready_i     (pixel_out.ready),
    .out_valid_o     (pixel_out.valid),
    .pixel_offset_o  (pixel_out.pixel_offset),
    .pixel_color_o   (pixel_out.pixel_color),
    .last_pixel_o    (pixel_out.last_pixel)
  );

endmodule

// File: test/textured_column_rasterizer_unit_tb.sv
`timescale 1ns / 1ps

module textured_column_rasterizer_unit_tb;
  import tcr_pkg::*;

  // action code the block takes and drops
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int LAST_ROW = VIEW_HEIGHT_DEF - 1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   table_index;
    logic [BYTE_W-1:0]   table_value;
    logic [BYTE_W-1:0]   column_x;
    logic [ROW_W-1:0]    top_row;
    logic [ROW_W-1:0]    bottom_row;
    logic [COORD_W-1:0]  inverse_scale;
    logic [COORD_W-1:0]  texture_mid;
  } col_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [BYTE_W-1:0]   color;
    logic                last;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tcr_item_if  item_if ();
  tcr_pixel_if pixel_if ();
  tcr_cfg_if   cfg_if ();

  textured_column_rasterizer_unit u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_in   (item_if),
    .pixel_out (pixel_if),
    .cfg_in    (cfg_if)
  );

  // shadow of the block's tables and registers
  logic [BYTE_W-1:0] light_tbl [MAP_DEPTH];
  logic [BYTE_W-1:0] texel_tbl [TEXEL_DEPTH];
  bit                light_set [MAP_DEPTH];
  bit                texel_set [TEXEL_DEPTH];
  logic [BYTE_W-1:0] view_width;
  logic [ROW_W-1:0]  center_row;

  pixel_t expected_pixels [$];
  int     mismatch_count;
  bit     stall_on;
  int     ready_hold;

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // texel slot read on a given row, closed form of the fraction walk
  function automatic logic [TEXEL_AW-1:0] texel_slot(col_item_t it, int row);
    logic [FRAC_W-1:0] step;
    logic [FRAC_W-1:0] delta;
    logic [FRAC_W-1:0] frac;
    step  = FRAC_W'(it.inverse_scale >> STEP_SHIFT);
    delta = FRAC_W'(row) - FRAC_W'(center_row);
    frac  = FRAC_W'(it.texture_mid >> STEP_SHIFT) + delta * step;
    return TEXEL_AW'(frac >> INDEX_SHIFT);
  endfunction

  function automatic int clipped_bottom(col_item_t it);
    return (int'(it.bottom_row) > LAST_ROW) ? LAST_ROW : int'(it.bottom_row);
  endfunction

  // expected pixels of one draw item
  function automatic void predict_column(col_item_t it);
    int     last;
    pixel_t px;
    last = clipped_bottom(it);
    for (int row = int'(it.top_row); row <= last; row++) begin
      px.offset = OFFSET_W'(row * int'(view_width) + int'(it.column_x));
      px.color  = light_tbl[texel_tbl[texel_slot(it, row)]];
      px.last   = (row == last);
      expected_pixels.push_back(px);
    end
  endfunction

  // update the shadow state for an accepted item
  function automatic void apply_item(col_item_t it);
    case (it.action)
      ACT_LOAD_LIGHT: begin
        light_tbl[it.table_index] = it.table_value;
        light_set[it.table_index] = 1'b1;
      end
      ACT_LOAD_TEXEL: begin
        texel_tbl[it.table_index[TEXEL_AW-1:0]] = it.table_value;
        texel_set[it.table_index[TEXEL_AW-1:0]] = 1'b1;
      end
      ACT_DRAW: predict_column(it);
      default: ;
    endcase
  endfunction

  function automatic col_item_t random_item(logic [ACTION_W-1:0] action);
    col_item_t it;
    it.action        = action;
    it.table_index   = BYTE_W'($urandom);
    it.table_value   = BYTE_W'($urandom);
    it.column_x      = BYTE_W'($urandom);
    it.top_row       = ROW_W'($urandom);
    it.bottom_row    = ROW_W'($urandom);
    it.inverse_scale = $urandom;
    it.texture_mid   = $urandom;
    return it;
  endfunction

  // send one item, with an optional idle burst in front
  task automatic send_item(col_item_t it);
    int gap;
    gap = (stall_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      item_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    item_if.valid         <= 1'b1;
    item_if.action        <= it.action;
    item_if.table_index   <= it.table_index;
    item_if.table_value   <= it.table_value;
    item_if.column_x      <= it.column_x;
    item_if.top_row       <= it.top_row;
    item_if.bottom_row    <= it.bottom_row;
    item_if.inverse_scale <= it.inverse_scale;
    item_if.texture_mid   <= it.texture_mid;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    apply_item(it);
  endtask

  task automatic send_load(logic [ACTION_W-1:0] action, logic [BYTE_W-1:0] index,
                           logic [BYTE_W-1:0] value);
    col_item_t it;
    it = random_item(action);
    it.table_index = index;
    it.table_value = value;
    send_item(it);
  endtask

  // load any table entry the column would read before it was ever written
  task automatic draw_column(col_item_t it);
    logic [TEXEL_AW-1:0] slot;
    int last;
    last = clipped_bottom(it);
    for (int row = int'(it.top_row); row <= last; row++) begin
      slot = texel_slot(it, row);
      if (!texel_set[slot])
        send_load(ACT_LOAD_TEXEL, {1'($urandom_range(0, 1)), slot}, BYTE_W'($urandom));
      if (!light_set[texel_tbl[slot]])
        send_load(ACT_LOAD_LIGHT, texel_tbl[slot], BYTE_W'($urandom));
    end
    it.action = ACT_DRAW;
    send_item(it);
  endtask

  task automatic draw_fixed(logic [BYTE_W-1:0] x, logic [ROW_W-1:0] top,
                            logic [ROW_W-1:0] bottom, logic [COORD_W-1:0] iscale,
                            logic [COORD_W-1:0] tmid);
    col_item_t it;
    it = random_item(ACT_DRAW);
    it.column_x      = x;
    it.top_row       = top;
    it.bottom_row    = bottom;
    it.inverse_scale = iscale;
    it.texture_mid   = tmid;
    draw_column(it);
  endtask

  // stop sending until every pixel is back and the block has settled
  task automatic wait_for_pixels_done();
    @(negedge clk_i);
    item_if.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [BYTE_W-1:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (index == CFG_VIEW_WIDTH) view_width = data;
    else if (index == CFG_CENTER_ROW) center_row = data[ROW_W-1:0];
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // table loads at the index extremes and columns at the field extremes
  task automatic test_directed_columns();
    send_load(ACT_LOAD_LIGHT, 8'd0, 8'hFF);
    send_load(ACT_LOAD_LIGHT, 8'hFF, 8'h00);
    send_load(ACT_LOAD_TEXEL, 8'd0, 8'hFF);
    send_load(ACT_LOAD_TEXEL, 8'hFF, 8'h00);
    send_load(ACT_LOAD_TEXEL, 8'h80, 8'h5A);
    // full height, zero step
    draw_fixed(8'd0, 6'd0, 6'd63, 32'h0000_0000, 32'h0000_0000);
    // single row at the bottom, all-ones step
    draw_fixed(8'hFF, 6'd63, 6'd63, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    draw_fixed(8'hFF, 6'd10, 6'd40, 32'hFFFF_FFFF, 32'h8000_0000);
    // one texel per row
    draw_fixed(8'h55, 6'd50, 6'd63, 32'h0001_0000, 32'hFFFF_FFFF);
    // empty columns
    draw_fixed(8'h12, 6'd40, 6'd39, $urandom, $urandom);
    draw_fixed(8'h34, 6'd63, 6'd0, $urandom, $urandom);
    // unused action is dropped
    send_item(random_item(ACT_UNUSED));
    draw_fixed(8'hAA, 6'd31, 6'd33, 32'h0000_8000, 32'h0000_0000);
    wait_for_pixels_done();
  endtask

  // register extremes, zero width included
  task automatic test_register_extremes();
    write_register(CFG_VIEW_WIDTH, 8'd0);
    write_register(CFG_CENTER_ROW, 8'd0);
    draw_fixed(8'h0F, 6'd0, 6'd7, 32'h0000_4000, 32'h0010_0000);
    wait_for_pixels_done();
    write_register(CFG_VIEW_WIDTH, 8'd255);
    write_register(CFG_CENTER_ROW, 8'hFF);
    draw_fixed(8'hFF, 6'd0, 6'd63, 32'h0000_0800, 32'hFFF0_0000);
    wait_for_pixels_done();
    write_register(CFG_VIEW_WIDTH, 8'd1);
    write_register(CFG_CENTER_ROW, 8'd63);
    draw_fixed(8'h80, 6'd20, 6'd29, 32'h0003_0000, 32'h0123_4567);
    wait_for_pixels_done();
  endtask

  // mostly well-formed columns with random content, some loads and noise
  task automatic test_random_phase(int count, bit stalls);
    col_item_t it;
    int pick;
    stall_on = stalls;
    write_register(CFG_VIEW_WIDTH, BYTE_W'($urandom));
    write_register(CFG_CENTER_ROW, BYTE_W'($urandom));
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (i == count / 2) wait_for_pixels_done();
      if (pick < 70) begin
        it = random_item(ACT_DRAW);
        if ($urandom_range(0, 9) != 0)
          it.bottom_row = ROW_W'($urandom_range(int'(it.top_row), LAST_ROW));
        if ($urandom_range(0, 1) == 0)
          it.inverse_scale = $urandom_range(0, 32'h0002_0000);
        draw_column(it);
      end else if (pick < 82) begin
        send_item(random_item(ACT_LOAD_LIGHT));
      end else if (pick < 94) begin
        send_item(random_item(ACT_LOAD_TEXEL));
      end else begin
        send_item(random_item(ACT_UNUSED));
      end
    end
    wait_for_pixels_done();
  endtask

  // receiver stalls in bursts
  always @(negedge clk_i) begin
    if (stall_on && ready_hold == 0 && $urandom_range(0, 5) == 0)
      ready_hold = $urandom_range(1, 19);
    if (ready_hold > 0) begin
      ready_hold--;
      pixel_if.ready <= 1'b0;
    end else begin
      pixel_if.ready <= 1'b1;
    end
  end

  // compare each pixel with the oldest expectation
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && pixel_if.valid && pixel_if.ready) begin
      if (expected_pixels.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected pixel: offset %0d color %0d last %0b",
                   pixel_if.pixel_offset, pixel_if.pixel_color, pixel_if.last_pixel);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_if.pixel_offset !== want.offset || pixel_if.pixel_color !== want.color ||
            pixel_if.last_pixel !== want.last) begin
          if (mismatch_count < 10)
            $display("pixel mismatch: expected offset %0d color %0d last %0b, got %0d %0d %0b",
                     want.offset, want.color, want.last, pixel_if.pixel_offset,
                     pixel_if.pixel_color, pixel_if.last_pixel);
          mismatch_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    #1_500_000;
    $display("textured_column_rasterizer_unit_tb NOT OK");
    $finish;
  end

  // test sequence
  initial begin
    rst_ni                = 1'b0;
    stall_on              = 1'b1;
    ready_hold            = 0;
    mismatch_count        = 0;
    view_width            = VIEW_WIDTH_RST;
    center_row            = CENTER_ROW_RST;
    item_if.valid         = 1'b0;
    item_if.action        = ACT_LOAD_LIGHT;
    item_if.table_index   = '0;
    item_if.table_value   = '0;
    item_if.column_x      = '0;
    item_if.top_row       = '0;
    item_if.bottom_row    = '0;
    item_if.inverse_scale = '0;
    item_if.texture_mid   = '0;
    pixel_if.ready        = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = CFG_VIEW_WIDTH;
    cfg_if.data           = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_columns();
    test_register_extremes();
    test_random_phase(40, 1'b1);
    test_random_phase(40, 1'b1);
    test_random_phase(40, 1'b0);

    repeat (20) @(posedge clk_i);
    if (expected_pixels.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("textured_column_rasterizer_unit_tb OK");
    end else begin
      $display("textured_column_rasterizer_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
